/* hw/rtl/isc_pkg.sv */
// isc_pkg: shared sizes, codes and control structs of the image scaler
// used by isc_div, isc_ctrl, isc_dp and image_scaler_nearest_bilinear_top
package isc_pkg;

   // source store geometry
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_CHANNELS = 4;
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

   // field and register widths
   localparam int POS_W       = 10;
   localparam int CHAN_W      = 2;
   localparam int SAMPLE_W    = 8;
   localparam int SRC_SIZE_W  = 9;
   localparam int DST_SIZE_W  = 11;
   localparam int CH_CNT_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // derived datapath widths
   localparam int COORD_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int FRAC_W   = 8;
   localparam int QUO_W    = COORD_W + FRAC_W;
   localparam int PROD_W   = POS_W + COORD_W;
   localparam int DIV_NUM_W = PROD_W + FRAC_W;
   localparam int DIV_DEN_W = DST_SIZE_W;
   localparam int PIX_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int LERP_W   = 2 * SAMPLE_W + FRAC_W;
   localparam int ACC_W    = 2 * SAMPLE_W;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_CHANNELS   = 3'd4,
      CSR_SCALE_MODE = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

   typedef enum logic {
      MODE_NEAREST  = 1'b0,
      MODE_BILINEAR = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      LERP_LOWER = 2'd0,
      LERP_UPPER = 2'd1,
      LERP_FINAL = 2'd2
   } lerp_sel_type;

   typedef struct packed {
      logic [SRC_SIZE_W-1:0] src_width;
      logic [SRC_SIZE_W-1:0] src_height;
      logic [DST_SIZE_W-1:0] dst_width;
      logic [DST_SIZE_W-1:0] dst_height;
      logic [CH_CNT_W-1:0]   channels;
      mode_type              scale_mode;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         map_load;
      logic         div_load;
      logic         div_step;
      logic         addr_mul;
      logic         addr_sum;
      logic         addr_wr;
      logic [1:0]   nbr;
      logic         mem_wr;
      logic         mem_rd;
      logic         slot_load;
      lerp_sel_type lerp_sel;
      logic         lerp_load;
      logic         out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

/* hw/rtl/isc_div.sv */
// isc_div: restoring divider, one quotient bit per cycle while step is high
// depends on isc_pkg for the operand widths
module isc_div import isc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 step,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [QUO_W-1:0]     quo,
   output logic                 last
);

   localparam int CNT_W = $clog2(QUO_W);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   // quotient fits QUO_W bits, so the top numerator bits are already below den
   always_comb begin
      trial  = {rem_ff, q_ff[QUO_W-1]};
      ge     = trial >= {1'b0, den};
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = DIV_DEN_W'(num[DIV_NUM_W-1:QUO_W]);
         q_in   = num[QUO_W-1:0];
         cnt_in = '0;
      end else if (step) begin
         rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
         q_in   = {q_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quo  = q_ff;
   assign last = (cnt_ff == CNT_W'(QUO_W - 1));

endmodule

/* hw/rtl/isc_ctrl.sv */
// isc_ctrl: sequencer of the image scaler, drives the datapath by command beats
// depends on isc_pkg for cmd_type, sts_type and the code enums
module isc_ctrl import isc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_opcode,
   input  mode_type   scale_mode,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_MAP      = 12'b0000_0000_0010,
      ST_DIV_LOAD = 12'b0000_0000_0100,
      ST_DIV_RUN  = 12'b0000_0000_1000,
      ST_ADDR_MUL = 12'b0000_0001_0000,
      ST_ADDR_SUM = 12'b0000_0010_0000,
      ST_MEM_WR   = 12'b0000_0100_0000,
      ST_MEM_RD   = 12'b0000_1000_0000,
      ST_CAPTURE  = 12'b0001_0000_0000,
      ST_LERP_LO  = 12'b0010_0000_0000,
      ST_LERP_HI  = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   localparam logic [1:0] NBR_FIRST = 2'b00;
   localparam logic [1:0] NBR_LAST  = 2'b11;

   state_type  state_ff, state_in;
   logic [1:0] nbr_ff, nbr_in;
   logic       wr_ff, wr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] nbr_end;

   assign nbr_end = (scale_mode == MODE_BILINEAR) ? NBR_LAST : NBR_FIRST;

   always_comb begin
      state_in     = state_ff;
      nbr_in       = nbr_ff;
      wr_in        = wr_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.addr_wr  = wr_ff;
      cmd.nbr      = nbr_ff;
      cmd.lerp_sel = LERP_LOWER;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               nbr_in      = NBR_FIRST;
               wr_in       = (req_opcode == OP_WRITE);
               state_in    = (req_opcode == OP_WRITE) ? ST_ADDR_MUL : ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_load = 1'b1;
            state_in     = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_ADDR_MUL;
            end
         end
         ST_ADDR_MUL: begin
            cmd.addr_mul = 1'b1;
            state_in     = ST_ADDR_SUM;
         end
         ST_ADDR_SUM: begin
            cmd.addr_sum = 1'b1;
            state_in     = wr_ff ? ST_MEM_WR : ST_MEM_RD;
         end
         ST_MEM_WR: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_MEM_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            cmd.slot_load = 1'b1;
            if (nbr_ff == nbr_end) begin
               state_in = (scale_mode == MODE_BILINEAR) ? ST_LERP_LO : ST_DONE;
            end else begin
               nbr_in   = nbr_ff + 1'b1;
               state_in = ST_ADDR_MUL;
            end
         end
         ST_LERP_LO: begin
            cmd.lerp_load = 1'b1;
            cmd.lerp_sel  = LERP_LOWER;
            state_in      = ST_LERP_HI;
         end
         ST_LERP_HI: begin
            cmd.lerp_load = 1'b1;
            cmd.lerp_sel  = LERP_UPPER;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            cmd.out_load = 1'b1;
            cmd.lerp_sel = LERP_FINAL;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nbr_ff       <= NBR_FIRST;
         wr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nbr_ff       <= nbr_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/isc_dp.sv */
// isc_dp: image scaler datapath: position mapping, address arithmetic,
// source store, blend unit and result register; uses isc_pkg and isc_div
module isc_dp import isc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample_in,
   output sts_type               sts,
   output logic [SAMPLE_W-1:0]   rsp_sample_out
);

   // captured request
   logic [POS_W-1:0]    pos_x_ff, pos_y_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   // effective sizes
   logic [SRC_SIZE_W-1:0] sw_eff, sh_eff;
   logic [COORD_W-1:0]    wm1;
   logic [ROW_W-1:0]      hm1;
   logic [DST_SIZE_W-1:0] dw_eff, dh_eff, dwm1, dhm1;
   logic [CH_CNT_W-1:0]   ch_eff, chm1;
   logic [CHAN_W-1:0]     chan_cl;
   logic                  one_x, one_y;

   // mapping
   logic [POS_W-1:0]     dcl_x, dcl_y;
   logic [PROD_W-1:0]    prod_x_ff, prod_y_ff;
   logic [QUO_W-1:0]     quo_x, quo_y, sx, sy;
   logic                 last_x, last_y;
   logic [COORD_W-1:0]   x0, x1, wx, xsel;
   logic [ROW_W-1:0]     y0, y1, wy, ysel;
   logic [FRAC_W-1:0]    ax, ay;

   // addressing
   logic [COORD_W-1:0]          xsel_ff;
   logic [ROW_W+SRC_SIZE_W-1:0] yw_full;
   logic [PIX_W-1:0]            yw_ff, pix;
   logic [PIX_W+CH_CNT_W-1:0]   addr_full;
   logic [ADDR_W-1:0]           addr_ff;

   // store and blend
   logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;
   logic [SAMPLE_W-1:0] slot_ff [4];
   logic [ACC_W-1:0]    lo_ff, hi_ff;
   logic [ACC_W-1:0]    la, lb;
   logic [FRAC_W-1:0]   lw;
   logic signed [ACC_W:0]         ldiff;
   logic signed [LERP_W+1:0]      lprod;
   logic [LERP_W+1:0]             lsum;
   logic [SAMPLE_W-1:0] out_ff;

   // saturate source sizes and channels; any zero size or count counts as one
   always_comb begin
      if (cfg.src_width == '0) begin
         sw_eff = SRC_SIZE_W'(1);
      end else if (cfg.src_width > SRC_SIZE_W'(MAX_WIDTH)) begin
         sw_eff = SRC_SIZE_W'(MAX_WIDTH);
      end else begin
         sw_eff = cfg.src_width;
      end
      if (cfg.src_height == '0) begin
         sh_eff = SRC_SIZE_W'(1);
      end else if (cfg.src_height > SRC_SIZE_W'(MAX_HEIGHT)) begin
         sh_eff = SRC_SIZE_W'(MAX_HEIGHT);
      end else begin
         sh_eff = cfg.src_height;
      end
      if (cfg.channels == '0) begin
         ch_eff = CH_CNT_W'(1);
      end else if (cfg.channels > CH_CNT_W'(MAX_CHANNELS)) begin
         ch_eff = CH_CNT_W'(MAX_CHANNELS);
      end else begin
         ch_eff = cfg.channels;
      end
      dw_eff = (cfg.dst_width == '0) ? DST_SIZE_W'(1) : cfg.dst_width;
      dh_eff = (cfg.dst_height == '0) ? DST_SIZE_W'(1) : cfg.dst_height;
   end

   assign wm1   = COORD_W'(sw_eff - 1'b1);
   assign hm1   = ROW_W'(sh_eff - 1'b1);
   assign dwm1  = dw_eff - 1'b1;
   assign dhm1  = dh_eff - 1'b1;
   assign one_x = (dwm1 == '0);
   assign one_y = (dhm1 == '0);
   assign chm1  = ch_eff - 1'b1;
   assign chan_cl = (CH_CNT_W'(chan_ff) > chm1) ? CHAN_W'(chm1) : chan_ff;

   // destination coordinate clamped to the last destination pixel
   assign dcl_x = (DST_SIZE_W'(pos_x_ff) > dwm1) ? POS_W'(dwm1) : pos_x_ff;
   assign dcl_y = (DST_SIZE_W'(pos_y_ff) > dhm1) ? POS_W'(dhm1) : pos_y_ff;

   isc_div u_div_x (
      .clock (clock),
      .reset (reset),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   ({prod_x_ff, FRAC_W'(0)}),
      .den   (dwm1),
      .quo   (quo_x),
      .last  (last_x)
   );

   isc_div u_div_y (
      .clock (clock),
      .reset (reset),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   ({prod_y_ff, FRAC_W'(0)}),
      .den   (dhm1),
      .quo   (quo_y),
      .last  (last_y)
   );

   // both dividers run in lock step
   assign sts.div_last = last_x & last_y;

   // q.8 source position, zero on an axis whose destination size is one pixel
   assign sx = one_x ? '0 : quo_x;
   assign sy = one_y ? '0 : quo_y;
   assign x0 = sx[QUO_W-1:FRAC_W];
   assign y0 = sy[QUO_W-1:FRAC_W];
   assign ax = sx[FRAC_W-1:0];
   assign ay = sy[FRAC_W-1:0];
   assign x1 = (x0 < wm1) ? x0 + 1'b1 : wm1;
   assign y1 = (y0 < hm1) ? y0 + 1'b1 : hm1;

   // write coordinates clamped to the source size
   assign wx = (pos_x_ff > POS_W'(wm1)) ? wm1 : COORD_W'(pos_x_ff);
   assign wy = (pos_y_ff > POS_W'(hm1)) ? hm1 : ROW_W'(pos_y_ff);

   assign xsel = cmd.addr_wr ? wx : (cmd.nbr[0] ? x1 : x0);
   assign ysel = cmd.addr_wr ? wy : (cmd.nbr[1] ? y1 : y0);

   assign yw_full   = ysel * sw_eff;
   assign pix       = PIX_W'(xsel_ff) + yw_ff;
   assign addr_full = pix * ch_eff + (PIX_W + CH_CNT_W)'(chan_cl);

   // shared blend: a*256 + w*(b-a)
   always_comb begin
      case (cmd.lerp_sel)
         LERP_LOWER: begin
            la = ACC_W'(slot_ff[0]);
            lb = ACC_W'(slot_ff[1]);
            lw = ax;
         end
         LERP_UPPER: begin
            la = ACC_W'(slot_ff[2]);
            lb = ACC_W'(slot_ff[3]);
            lw = ax;
         end
         LERP_FINAL: begin
            la = lo_ff;
            lb = hi_ff;
            lw = ay;
         end
         default: begin
            la = '0;
            lb = '0;
            lw = '0;
         end
      endcase
      ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
      lprod = ldiff * $signed({1'b0, lw});
      lsum  = (LERP_W + 2)'({la, FRAC_W'(0)}) + $unsigned(lprod);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         chan_ff   <= req_channel;
         sample_ff <= req_sample_in;
      end
      if (cmd.map_load) begin
         prod_x_ff <= dcl_x * wm1;
         prod_y_ff <= dcl_y * hm1;
      end
      if (cmd.addr_mul) begin
         xsel_ff <= xsel;
         yw_ff   <= yw_full[PIX_W-1:0];
      end
      if (cmd.addr_sum) begin
         addr_ff <= addr_full[ADDR_W-1:0];
      end
      if (cmd.slot_load) begin
         slot_ff[cmd.nbr] <= rdata_ff;
      end
      if (cmd.lerp_load && (cmd.lerp_sel == LERP_LOWER)) begin
         lo_ff <= lsum[ACC_W-1:0];
      end
      if (cmd.lerp_load && (cmd.lerp_sel == LERP_UPPER)) begin
         hi_ff <= lsum[ACC_W-1:0];
      end
      if (cmd.out_load) begin
         out_ff <= (cfg.scale_mode == MODE_BILINEAR) ?
                   lsum[LERP_W-1:ACC_W] : slot_ff[0];
      end
   end

   // single port source store
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         store_mem[addr_ff] <= sample_ff;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= store_mem[addr_ff];
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

/* hw/rtl/image_scaler_nearest_bilinear_top.sv */
// image_scaler_nearest_bilinear_top: nearest / bilinear image scaler top level
// holds the configuration registers; instantiates isc_ctrl and isc_dp (isc_pkg)
//
// usage
//   req channel: a beat is taken at a rising edge with start high and busy low.
//     opcode write stores sample_in at (pos_x, pos_y, channel) of the source
//     image, coordinates clamped to the configured source size. opcode read
//     asks for one destination sample and gives exactly one result beat.
//   rsp channel: rsp_valid is high for one cycle with rsp_sample_out; the
//     receiver cannot stall, the beat is taken at the edge ending that cycle.
//     the strobe cycle is idle, so the next request may be taken in it.
//   csr channel: csr_ready is always high; a beat writes register csr_index,
//     unused indexes are dropped. write only while the block is idle.
//   steps, accept to next possible accept:
//     write: address multiply, address sum, store write, back to idle
//     read: position map, divider load, bit-serial divide, then per neighbour
//     (1 nearest, 4 bilinear, one by one from the single port store) address
//     multiply, address sum, read, capture; bilinear row blends; result load
//   reset: synchronous, active high; registers go to 1x1 source and
//     destination, 3 channels, nearest mode. the source store is not
//     cleared, samples read before being written are undefined.
module image_scaler_nearest_bilinear_top import isc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,
   input  logic [CHAN_W-1:0]      req_channel,
   input  logic [SAMPLE_W-1:0]    req_sample_in,
   // result
   output logic                   rsp_valid,
   output logic [SAMPLE_W-1:0]    rsp_sample_out,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;

   // configuration register file, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SRC_WIDTH:  cfg_in.src_width  = csr_data[SRC_SIZE_W-1:0];
            CSR_SRC_HEIGHT: cfg_in.src_height = csr_data[SRC_SIZE_W-1:0];
            CSR_DST_WIDTH:  cfg_in.dst_width  = csr_data[DST_SIZE_W-1:0];
            CSR_DST_HEIGHT: cfg_in.dst_height = csr_data[DST_SIZE_W-1:0];
            CSR_CHANNELS:   cfg_in.channels   = csr_data[CH_CNT_W-1:0];
            CSR_SCALE_MODE: cfg_in.scale_mode = mode_type'(csr_data[0]);
            default: begin
               // index past the register list: beat is dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= SRC_SIZE_W'(1);
         cfg_ff.src_height <= SRC_SIZE_W'(1);
         cfg_ff.dst_width  <= DST_SIZE_W'(1);
         cfg_ff.dst_height <= DST_SIZE_W'(1);
         cfg_ff.channels   <= CH_CNT_W'(3);
         cfg_ff.scale_mode <= MODE_NEAREST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: takes the request beat and steps the datapath
   isc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .scale_mode (cfg_ff.scale_mode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   // mapping, addressing, source store and blend
   isc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .sts            (sts),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
